FILE: hw/rtl/fdc_pkg.sv
// shared constants, types and helper functions of the double-word compressor
package fdc_pkg;

  localparam int WORD_W        = 64;
  localparam int CFG_W         = 5;
  localparam int CODE_W        = 3;
  localparam int BYTES_W       = 4;
  localparam int TBL_BITS      = 16;
  localparam int TBL_DEPTH     = 1 << TBL_BITS;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QUEUE_PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int FCM_SHIFT     = 6;
  localparam int DFCM_SHIFT    = 2;
  localparam int FCM_HASH_POS  = 48;
  localparam int DFCM_HASH_POS = 40;

  localparam logic [CFG_W-1:0] PBITS_RESET = CFG_W'(16);

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [WORD_W-1:0] fcm_pred;
    logic [WORD_W-1:0] dfcm_pred;
  } pred_beat_t;

  typedef struct packed {
    logic               use_stride;
    logic [CODE_W-1:0]  code;
    logic [WORD_W-1:0]  residual;
    logic [BYTES_W-1:0] nbytes;
  } res_beat_t;

  function automatic logic [TBL_BITS-1:0] table_mask(input logic [CFG_W-1:0] bits);
    logic [TBL_BITS-1:0] m;
    for (int i = 0; i < TBL_BITS; i++) begin
      m[i] = (i < int'(bits));
    end
    return m;
  endfunction

  function automatic logic [CODE_W-1:0] byte_code(input logic [WORD_W-1:0] r);
    logic [CODE_W-1:0] c;
    c = CODE_W'(7);
    if (r[63:56] == '0) c = CODE_W'(6);
    if (r[63:48] == '0) c = CODE_W'(5);
    if (r[63:40] == '0) c = CODE_W'(4);
    if (r[63:24] == '0) c = CODE_W'(3);
    if (r[63:16] == '0) c = CODE_W'(2);
    if (r[63:8] == '0)  c = CODE_W'(1);
    if (r == '0)        c = CODE_W'(0);
    return c;
  endfunction

endpackage

FILE: hw/rtl/fcm_dfcm_double_compressor_top.sv
// Double-word compressor front end with FCM and DFCM predictors. Takes one
// 64-bit word per beat and returns one residual beat per input: predictor
// choice, 3-bit byte code, residual word and byte count. Sustained rate is
// one beat per cycle while the output is not stalled, held by the hash update
// and table read loop in the predictor. out_valid_o rises once an input beat
// has passed one register stage each in the input queue, the predictor and
// the output register. After reset both 65536-entry tables are cleared one
// entry per cycle and in_ready_o stays low meanwhile. predictor_bits writes are
// taken at any time but are meant for an idle block; values above 16 act as 16.
module fcm_dfcm_double_compressor_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [fdc_pkg::CFG_W-1:0]   cfg_predictor_bits_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [fdc_pkg::WORD_W-1:0]  value_word_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        use_stride_predictor_o,
  output logic [fdc_pkg::CODE_W-1:0]  length_code_o,
  output logic [fdc_pkg::WORD_W-1:0]  residual_word_o,
  output logic [fdc_pkg::BYTES_W-1:0] residual_bytes_o
);
  import fdc_pkg::*;

  logic [CFG_W-1:0]  pbits_q;
  logic              q_full, q_valid, q_pop, clearing, push;
  logic [WORD_W-1:0] q_word;
  logic              p_valid, p_ready;
  pred_beat_t        p_beat;
  res_beat_t         out_beat;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pbits_q <= PBITS_RESET;
    end else if (cfg_valid_i) begin
      pbits_q <= cfg_predictor_bits_i;
    end
  end

  assign in_ready_o = !q_full && !clearing;
  assign push       = in_valid_i && in_ready_o;

  fdc_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_word_i (value_word_i),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .word_o      (q_word)
  );

  fdc_predictor u_pred (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pbits_i    (pbits_q),
    .q_valid_i  (q_valid),
    .q_word_i   (q_word),
    .q_pop_o    (q_pop),
    .clearing_o (clearing),
    .p_valid_o  (p_valid),
    .p_beat_o   (p_beat),
    .p_ready_i  (p_ready)
  );

  fdc_encoder u_enc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .p_valid_i   (p_valid),
    .p_beat_i    (p_beat),
    .p_ready_o   (p_ready),
    .out_valid_o (out_valid_o),
    .out_beat_o  (out_beat),
    .out_ready_i (out_ready_i)
  );

  assign use_stride_predictor_o = out_beat.use_stride;
  assign length_code_o          = out_beat.code;
  assign residual_word_o        = out_beat.residual;
  assign residual_bytes_o       = out_beat.nbytes;

endmodule

FILE: hw/rtl/fdc_fifo.sv
// short input queue between the accepting front and the predictor back
module fdc_fifo (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [fdc_pkg::WORD_W-1:0] push_word_i,
  output logic                       full_o,
  input  logic                       pop_i,
  output logic                       valid_o,
  output logic [fdc_pkg::WORD_W-1:0] word_o
);
  import fdc_pkg::*;

  logic [WORD_W-1:0]      mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [QUEUE_CNT_W-1:0] cnt_q, cnt_d;

  function automatic logic [QUEUE_PTR_W-1:0] ptr_inc(input logic [QUEUE_PTR_W-1:0] p);
    return (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QUEUE_PTR_W'(1);
  endfunction

  assign full_o  = (cnt_q == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign word_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = push_i ? ptr_inc(wptr_q) : wptr_q;
    rptr_d = pop_i ? ptr_inc(rptr_q) : rptr_q;
    cnt_d  = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + QUEUE_CNT_W'(1);
    if (!push_i && pop_i) cnt_d = cnt_q - QUEUE_CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= push_word_i;
  end

endmodule

FILE: hw/rtl/fdc_predictor.sv
// fcm and dfcm prediction tables, hash update and table clearing
module fdc_predictor (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [fdc_pkg::CFG_W-1:0]  pbits_i,
  input  logic                       q_valid_i,
  input  logic [fdc_pkg::WORD_W-1:0] q_word_i,
  output logic                       q_pop_o,
  output logic                       clearing_o,
  output logic                       p_valid_o,
  output fdc_pkg::pred_beat_t        p_beat_o,
  input  logic                       p_ready_i
);
  import fdc_pkg::*;

  logic [WORD_W-1:0]   lv_mem [TBL_DEPTH];
  logic [WORD_W-1:0]   st_mem [TBL_DEPTH];

  logic                clearing_q, clearing_d;
  logic [TBL_BITS-1:0] clr_addr_q, clr_addr_d;
  logic [TBL_BITS-1:0] vh_q, vh_d, sh_q, sh_d;
  logic [WORD_W-1:0]   prev_q, last_stride_q;
  logic [WORD_W-1:0]   lv_rd_q, st_rd_q;
  logic                vfwd_q, sfwd_q;
  logic                p_valid_q;
  pred_beat_t          p_beat_q;

  logic [TBL_BITS-1:0] mask_w;
  logic                fire;
  logic [WORD_W-1:0]   vpred, spred, stride;
  logic                tbl_we;
  logic [TBL_BITS-1:0] lv_wa, st_wa;
  logic [WORD_W-1:0]   lv_wd, st_wd;

  assign mask_w = table_mask(pbits_i);
  assign fire   = q_valid_i && !clearing_q && (!p_valid_q || p_ready_i);
  assign vpred  = vfwd_q ? prev_q : lv_rd_q;
  assign spred  = sfwd_q ? last_stride_q : st_rd_q;
  assign stride = q_word_i - prev_q;

  always_comb begin
    vh_d = vh_q;
    sh_d = sh_q;
    if (fire) begin
      vh_d = ((vh_q << FCM_SHIFT) ^ TBL_BITS'(q_word_i >> FCM_HASH_POS)) & mask_w;
      sh_d = ((sh_q << DFCM_SHIFT) ^ TBL_BITS'(stride >> DFCM_HASH_POS)) & mask_w;
    end
  end

  always_comb begin
    clearing_d = clearing_q && (clr_addr_q != '1);
    clr_addr_d = clearing_q ? clr_addr_q + TBL_BITS'(1) : clr_addr_q;
  end

  // table write port, shared by the clearing pass and item updates
  assign tbl_we = clearing_q || fire;
  assign lv_wa  = clearing_q ? clr_addr_q : vh_q;
  assign st_wa  = clearing_q ? clr_addr_q : sh_q;
  assign lv_wd  = clearing_q ? '0 : q_word_i;
  assign st_wd  = clearing_q ? '0 : stride;

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      lv_mem[lv_wa] <= lv_wd;
      st_mem[st_wa] <= st_wd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lv_rd_q <= '0;
      st_rd_q <= '0;
    end else if (fire) begin
      lv_rd_q <= lv_mem[vh_d];
      st_rd_q <= st_mem[sh_d];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q    <= 1'b1;
      clr_addr_q    <= '0;
      vh_q          <= '0;
      sh_q          <= '0;
      prev_q        <= '0;
      last_stride_q <= '0;
      vfwd_q        <= 1'b0;
      sfwd_q        <= 1'b0;
      p_valid_q     <= 1'b0;
    end else begin
      clearing_q <= clearing_d;
      clr_addr_q <= clr_addr_d;
      vh_q       <= vh_d;
      sh_q       <= sh_d;
      if (fire) begin
        prev_q        <= q_word_i;
        last_stride_q <= stride;
        // next read hits the entry written by this beat
        vfwd_q        <= (vh_d == vh_q);
        sfwd_q        <= (sh_d == sh_q);
        p_valid_q     <= 1'b1;
      end else if (p_ready_i) begin
        p_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      p_beat_q.word      <= q_word_i;
      p_beat_q.fcm_pred  <= vpred;
      p_beat_q.dfcm_pred <= prev_q + spred;
    end
  end

  assign q_pop_o    = fire;
  assign clearing_o = clearing_q;
  assign p_valid_o  = p_valid_q;
  assign p_beat_o   = p_beat_q;

`ifndef SYNTHESIS
  a_hash_masked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> (((vh_q | sh_q) & ~$past(mask_w)) == '0))
    else $error("hash outside table mask");
  a_clear_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !clearing_q |=> !clearing_q)
    else $error("clearing pass restarted");
  a_no_beat_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_q |-> (!p_valid_q && !fire))
    else $error("beat issued during clearing pass");
`endif

endmodule

FILE: hw/rtl/fdc_encoder.sv
// residual selection, leading-zero-byte coding and output register
module fdc_encoder (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        p_valid_i,
  input  fdc_pkg::pred_beat_t         p_beat_i,
  output logic                        p_ready_o,
  output logic                        out_valid_o,
  output fdc_pkg::res_beat_t          out_beat_o,
  input  logic                        out_ready_i
);
  import fdc_pkg::*;

  logic              out_valid_q;
  res_beat_t         out_q, out_d;
  logic              load;
  logic [WORD_W-1:0] r_fcm, r_dfcm;
  logic              pick;
  logic [CODE_W-1:0] code;

  assign p_ready_o = !out_valid_q || out_ready_i;
  assign load      = p_valid_i && p_ready_o;

  always_comb begin
    r_fcm  = p_beat_i.word ^ p_beat_i.fcm_pred;
    r_dfcm = p_beat_i.word ^ p_beat_i.dfcm_pred;
    // tie keeps fcm
    pick   = (r_fcm > r_dfcm);
    out_d.use_stride = pick;
    out_d.residual   = pick ? r_dfcm : r_fcm;
    code             = byte_code(out_d.residual);
    out_d.code       = code;
    out_d.nbytes     = BYTES_W'(code) + BYTES_W'(code >> 2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

endmodule
